>>> rtl/yaz0_pkg.sv
// Shared types, codes and constants of the Yaz0 decompressor.
package yaz0_pkg;

    localparam int OUT_LANES  = 8;
    localparam int WIN_AW     = 12;
    localparam int WIN_DEPTH  = 1 << WIN_AW;
    localparam int SIZE_W     = 24;
    localparam int LEN_W      = 9;
    localparam int CNT_W      = 4;
    localparam logic [LEN_W-1:0] LONG_BIAS = 9'h012;
    localparam logic [LEN_W-1:0] SHORT_BIAS = 9'd2;
    localparam int TOP_FLAG   = 7;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_start;
    } in_word_t;

    typedef struct packed {
        logic [8*OUT_LANES-1:0] out_data;
        logic [CNT_W-1:0]       out_count;
        logic                   run_last;
        logic                   stream_done;
    } out_word_t;

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_TOKEN,
        PH_SECOND,
        PH_LENGTH
    } phase_t;

    typedef enum logic {
        ST_IDLE,
        ST_COPY
    } ctrl_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LIT,
        OP_HEAD,
        OP_SECOND,
        OP_LENGTH
    } op_t;

    typedef struct packed {
        logic       start;
        op_t        op;
        logic [7:0] data;
    } dp_cmd_t;

    typedef struct packed {
        logic complete;
        logic size_zero;
        logic nib_nz;
        logic busy;
    } dp_stat_t;

endpackage

>>> rtl/yaz0_ctrl.sv
// Token parser and sequencing state machine of the Yaz0 decompressor.
module yaz0_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  yaz0_pkg::in_word_t in_word,
    input  yaz0_pkg::dp_stat_t stat,
    output yaz0_pkg::dp_cmd_t  cmd
);
    import yaz0_pkg::*;

    ctrl_state_t state_reg, state_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  flag_reg, flag_next;
    logic [3:0]  left_reg, left_next;

    logic        accept;
    logic        start;
    phase_t      ph_eff;
    logic [7:0]  flg_eff;
    logic [3:0]  left_eff;
    logic        cpl_eff;

    // Resolve the view of parser state after a stream start
    always_comb
    begin
        accept   = in_valid & (state_reg == ST_IDLE);
        start    = accept & in_word.stream_start;
        ph_eff   = start ? PH_FLAG : phase_reg;
        flg_eff  = start ? 8'd0 : flag_reg;
        left_eff = start ? 4'd0 : left_reg;
        cpl_eff  = start ? stat.size_zero : stat.complete;
    end

    // Next state and parser registers
    always_comb
    begin
        state_next = state_reg;
        phase_next = ph_eff;
        flag_next  = flg_eff;
        left_next  = left_eff;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !cpl_eff)
                begin
                    unique case (ph_eff)
                        PH_FLAG:
                        begin
                            flag_next  = in_word.in_byte;
                            left_next  = 4'd8;
                            phase_next = PH_TOKEN;
                        end
                        PH_TOKEN:
                        begin
                            if (flg_eff[TOP_FLAG])
                            begin
                                state_next = ST_COPY;
                                flag_next  = {flg_eff[6:0], 1'b0};
                                left_next  = left_eff - 4'd1;
                                phase_next = (left_eff != 4'd1) ? PH_TOKEN : PH_FLAG;
                            end
                            else
                            begin
                                phase_next = PH_SECOND;
                            end
                        end
                        PH_SECOND:
                        begin
                            if (stat.nib_nz)
                            begin
                                state_next = ST_COPY;
                                flag_next  = {flg_eff[6:0], 1'b0};
                                left_next  = left_eff - 4'd1;
                                phase_next = (left_eff != 4'd1) ? PH_TOKEN : PH_FLAG;
                            end
                            else
                            begin
                                phase_next = PH_LENGTH;
                            end
                        end
                        PH_LENGTH:
                        begin
                            state_next = ST_COPY;
                            flag_next  = {flg_eff[6:0], 1'b0};
                            left_next  = left_eff - 4'd1;
                            phase_next = (left_eff != 4'd1) ? PH_TOKEN : PH_FLAG;
                        end
                        default:
                        begin
                            phase_next = PH_FLAG;
                        end
                    endcase
                end
            end
            ST_COPY:
            begin
                if (!stat.busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Drive handshake and datapath command
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        cmd.start = start;
        cmd.data  = in_word.in_byte;
        cmd.op    = OP_NONE;
        if (accept && !cpl_eff)
        begin
            unique case (ph_eff)
                PH_FLAG:   cmd.op = OP_NONE;
                PH_TOKEN:  cmd.op = flg_eff[TOP_FLAG] ? OP_LIT : OP_HEAD;
                PH_SECOND: cmd.op = OP_SECOND;
                PH_LENGTH: cmd.op = OP_LENGTH;
                default:   cmd.op = OP_NONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_FLAG;
            flag_reg  <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            left_reg  <= left_next;
        end
    end

endmodule

>>> rtl/yaz0_dp.sv
// History window, copy engine, byte packer and output register.
module yaz0_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  yaz0_pkg::dp_cmd_t   cmd,
    output yaz0_pkg::dp_stat_t  stat,
    input  logic               cfg_we,
    input  logic [23:0]        cfg_wdata,
    output logic               out_valid,
    input  logic               out_ready,
    output yaz0_pkg::out_word_t out_word
);
    import yaz0_pkg::*;

    logic [7:0] win_mem [WIN_DEPTH];
    logic [7:0] rd_q;

    logic [SIZE_W-1:0]      size_reg, size_next;
    logic [SIZE_W-1:0]      prod_reg, prod_next;
    logic [WIN_AW-1:0]      wr_reg, wr_next;
    logic [WIN_AW-1:0]      rd_reg, rd_next;
    logic [3:0]             nib_reg, nib_next;
    logic [WIN_AW-1:0]      off_reg, off_next;
    logic [LEN_W-1:0]       rem_reg, rem_next;
    logic                   pend_reg, pend_next;
    logic                   fwd_reg, fwd_next;
    logic [7:0]             prev_reg, prev_next;
    logic [8*OUT_LANES-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   ov_reg, ov_next;
    out_word_t              ow_reg, ow_next;

    logic              we, re;
    logic [WIN_AW-1:0] waddr, raddr;
    logic [7:0]        wdata, src_byte;
    logic              out_free, emit_need;
    logic [LEN_W-1:0]  len_raw;
    logic              copy_go;
    logic [WIN_AW-1:0] copy_off;
    logic [SIZE_W-1:0] owed;

    always_comb
    begin
        out_free  = !ov_reg | out_ready;
        emit_need = (cnt_reg == CNT_W'(OUT_LANES)) ||
                    ((cnt_reg != '0) && (rem_reg == '0) && !pend_reg);
        src_byte  = fwd_reg ? prev_reg : rd_q;
        owed      = size_reg - prod_reg;
    end

    // Copy engine, command decode and output register
    always_comb
    begin
        size_next = cfg_we ? cfg_wdata : size_reg;
        prod_next = prod_reg;
        wr_next   = wr_reg;
        rd_next   = rd_reg;
        nib_next  = nib_reg;
        off_next  = off_reg;
        rem_next  = rem_reg;
        pend_next = pend_reg;
        fwd_next  = fwd_reg;
        prev_next = prev_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        ov_next   = ov_reg & !out_ready;
        ow_next   = ow_reg;
        we        = 1'b0;
        re        = 1'b0;
        waddr     = wr_reg;
        raddr     = rd_reg;
        wdata     = src_byte;
        len_raw   = '0;
        copy_go   = 1'b0;
        copy_off  = off_reg;

        // Advance the copy: emit a full or final group, else move one byte
        if (emit_need)
        begin
            if (out_free)
            begin
                ov_next             = 1'b1;
                ow_next.out_data    = acc_reg;
                ow_next.out_count   = cnt_reg;
                ow_next.run_last    = (rem_reg == '0) && !pend_reg;
                ow_next.stream_done = (prod_reg >= size_reg);
                acc_next            = '0;
                cnt_next            = '0;
            end
        end
        else
        begin
            if (pend_reg)
            begin
                we        = 1'b1;
                wr_next   = wr_reg + 1'b1;
                prod_next = prod_reg + 1'b1;
                acc_next[{cnt_reg[2:0], 3'b000} +: 8] = src_byte;
                cnt_next  = cnt_reg + 1'b1;
                prev_next = src_byte;
                pend_next = 1'b0;
            end
            if (rem_reg != '0)
            begin
                re        = 1'b1;
                rd_next   = rd_reg + 1'b1;
                rem_next  = rem_reg - 1'b1;
                pend_next = 1'b1;
                fwd_next  = pend_reg && (rd_reg == wr_reg);
            end
        end

        // Clear stream counters on a stream start
        if (cmd.start)
        begin
            prod_next = '0;
            wr_next   = '0;
            nib_next  = '0;
            off_next  = '0;
        end

        // Decode the parser command
        case (cmd.op)
            OP_LIT:
            begin
                we        = 1'b1;
                wdata     = cmd.data;
                wr_next   = wr_reg + 1'b1;
                prod_next = prod_reg + 1'b1;
                acc_next  = {{(8*OUT_LANES-8){1'b0}}, cmd.data};
                cnt_next  = CNT_W'(1);
                prev_next = cmd.data;
            end
            OP_HEAD:
            begin
                nib_next = cmd.data[7:4];
                off_next = {cmd.data[3:0], 8'h00};
            end
            OP_SECOND:
            begin
                off_next = off_reg | {4'h0, cmd.data};
                copy_off = off_reg | {4'h0, cmd.data};
                len_raw  = {5'b0, nib_reg} + SHORT_BIAS;
                copy_go  = (nib_reg != 4'h0);
            end
            OP_LENGTH:
            begin
                len_raw = {1'b0, cmd.data} + LONG_BIAS;
                copy_go = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Load the copy engine, clipping to the bytes still owed
        if (copy_go)
        begin
            rd_next   = wr_reg - copy_off - 1'b1;
            rem_next  = ({{(SIZE_W-LEN_W){1'b0}}, len_raw} > owed) ? owed[LEN_W-1:0] : len_raw;
            pend_next = 1'b0;
        end
    end

    always_comb
    begin
        stat.complete  = (prod_reg >= size_reg);
        stat.size_zero = (size_reg == '0);
        stat.nib_nz    = (nib_reg != 4'h0);
        stat.busy      = (cnt_reg != '0) || (rem_reg != '0) || pend_reg;
        out_valid      = ov_reg;
        out_word       = ow_reg;
    end

    // History window write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            win_mem[waddr] <= wdata;
        end
    end

    // History window registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rd_q <= win_mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= '0;
            prod_reg <= '0;
            wr_reg   <= '0;
            nib_reg  <= '0;
            off_reg  <= '0;
            rem_reg  <= '0;
            pend_reg <= 1'b0;
            cnt_reg  <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            size_reg <= size_next;
            prod_reg <= prod_next;
            wr_reg   <= wr_next;
            nib_reg  <= nib_next;
            off_reg  <= off_next;
            rem_reg  <= rem_next;
            pend_reg <= pend_next;
            cnt_reg  <= cnt_next;
            ov_reg   <= ov_next;
        end
    end

    // Hold payload registers without reset
    always_ff @(posedge clk)
    begin
        rd_reg   <= rd_next;
        fwd_reg  <= fwd_next;
        prev_reg <= prev_next;
        acc_reg  <= acc_next;
        ow_reg   <= ow_next;
    end

endmodule

>>> rtl/yaz0_lz_decompressor_core.sv
// Top level of the Yaz0 decompressor: parser control plus datapath.
//
// Usage: program cfg_wdata (decompressed size) with cfg_we while idle,
// then feed the compressed bytes following the 16-byte header on the
// input channel, one byte per word, with stream_start set on the first.
// Each output word carries up to eight decoded bytes, earliest in bits
// 7:0, with out_count valid lanes; run_last marks the final word caused
// by an input byte and stream_done marks that the size is reached.
// Flag bytes and the leading bytes of a reference give no output. A
// literal passes through the byte packer into the output register and
// holds off the next input word until the packer has emitted it.
// A back-reference of L bytes is copied through the history window,
// which has one read port delivering one byte per cycle, except while a
// word is emitted or held by a stalled receiver. Input is not taken while a copy runs.
// Reset clears parser, counters and size; the window contents are
// undefined until written. When the receiver stalls, the output register
// holds its word and the copy engine pauses at the next full or final group.
module yaz0_lz_decompressor_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  yaz0_pkg::in_word_t   in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output yaz0_pkg::out_word_t  out_word,
    input  logic                cfg_we,
    input  logic [23:0]         cfg_wdata
);
    import yaz0_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    yaz0_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .stat     (stat),
        .cmd      (cmd)
    );

    yaz0_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

endmodule

>>> rtl/yaz0_checker.sv
// Port-level checks of the Yaz0 decompressor, bound to the top level.
module yaz0_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input yaz0_pkg::out_word_t  out_word
);
    import yaz0_pkg::*;

    // Hold a stalled output word
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_word))
        else $error("output word changed while stalled");

    // Count stays within the lanes
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.out_count != 4'd0) && (out_word.out_count <= 4'd8))
        else $error("output count out of range");

    // Only the final word of a run may be short
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_word.out_count == 4'd8) || out_word.run_last)
        else $error("short word before end of run");

endmodule

bind yaz0_lz_decompressor_core yaz0_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);

>>> tb/sv/yaz0_lz_decompressor_core_test.sv
// Self-checking testbench for the Yaz0 decompressor core.
`timescale 1ns / 100ps

module yaz0_lz_decompressor_core_test;
    import yaz0_pkg::*;

    localparam int WMASK   = WIN_DEPTH - 1;
    localparam int DRAIN   = 400;
    localparam int N_PHASE = 6;
    localparam int PER_PHASE = 66;
    localparam logic [23:0] SIZE_MAX = 24'h800000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_ready;
    out_word_t   out_word;
    logic        cfg_we;
    logic [23:0] cfg_wdata;

    yaz0_lz_decompressor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Decoder copy: window, parser and counters
    logic [7:0]        hist [WIN_DEPTH];
    bit                hist_written [WIN_DEPTH];
    logic [WIN_AW-1:0] wr_ptr;
    logic [7:0]        flags;
    logic [3:0]        flags_left;
    phase_t            phase;
    logic [3:0]        ref_nib;
    logic [11:0]       ref_off;
    logic [23:0]       produced;
    logic [23:0]       size_cfg;

    out_word_t decoded_q[$];
    out_word_t first_decoded;
    bit        had_decoded;
    int        errors;
    int        send_idle_pct;
    int        recv_idle_pct;
    logic [11:0] gen_off;

    typedef struct {
        bit          cfg_set;
        logic [23:0] cfg_val;
        in_word_t    w;
        bit          chk;
        out_word_t   e;
    } row_t;

    row_t rows[$];

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic bit size_reached();
        return produced >= size_cfg;
    endfunction

    function automatic void advance_token();
        flags      = flags << 1;
        flags_left = flags_left - 4'd1;
        phase      = (flags_left != 0) ? PH_TOKEN : PH_FLAG;
    endfunction

    function automatic void store_byte(input logic [7:0] b);
        hist[wr_ptr]         = b;
        hist_written[wr_ptr] = 1'b1;
        wr_ptr               = wr_ptr + 1'b1;
        produced             = produced + 1'b1;
    endfunction

    // Copy a back-reference, clipped to the bytes still owed, in groups of lanes
    function automatic void copy_ref(input int back_dist, input int len);
        int        owed;
        int        lane;
        logic [7:0] b;
        out_word_t o;
        owed = size_cfg - produced;
        if (len > owed)
            len = owed;
        lane = 0;
        o = '0;
        for (int i = 0; i < len; i++)
        begin
            b = hist[(wr_ptr - back_dist) & WMASK];
            store_byte(b);
            o.out_data[8*lane +: 8] = b;
            lane++;
            if (lane == OUT_LANES || i + 1 == len)
            begin
                o.out_count   = CNT_W'(lane);
                o.run_last    = (i + 1 == len);
                o.stream_done = size_reached();
                decoded_q.push_back(o);
                if (!had_decoded)
                    first_decoded = o;
                had_decoded = 1'b1;
                lane = 0;
                o = '0;
            end
        end
    endfunction

    // Decode one accepted compressed byte
    function automatic void decode_byte(input in_word_t w);
        out_word_t o;
        had_decoded = 1'b0;
        if (w.stream_start)
        begin
            phase      = PH_FLAG;
            flags_left = '0;
            flags      = '0;
            ref_nib    = '0;
            ref_off    = '0;
            produced   = '0;
            wr_ptr     = '0;
        end
        if (size_reached())
            return;
        case (phase)
            PH_FLAG:
            begin
                flags      = w.in_byte;
                flags_left = 4'd8;
                phase      = PH_TOKEN;
            end
            PH_TOKEN:
            begin
                if (flags[TOP_FLAG])
                begin
                    store_byte(w.in_byte);
                    o = '0;
                    o.out_data[7:0] = w.in_byte;
                    o.out_count     = 4'd1;
                    o.run_last      = 1'b1;
                    o.stream_done   = size_reached();
                    decoded_q.push_back(o);
                    first_decoded = o;
                    had_decoded   = 1'b1;
                    advance_token();
                end
                else
                begin
                    ref_nib = w.in_byte[7:4];
                    ref_off = {w.in_byte[3:0], 8'h00};
                    phase   = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                ref_off[7:0] = w.in_byte;
                if (ref_nib != 0)
                begin
                    copy_ref(ref_off + 1, ref_nib + SHORT_BIAS);
                    advance_token();
                end
                else
                    phase = PH_LENGTH;
            end
            default:
            begin
                copy_ref(ref_off + 1, w.in_byte + LONG_BIAS);
                advance_token();
            end
        endcase
    endfunction

    // Count written window entries directly behind a write pointer
    function automatic int history_reach(input logic [WIN_AW-1:0] wp);
        int k;
        k = 0;
        while (k < WIN_DEPTH && hist_written[(wp - k - 1) & WMASK])
            k++;
        return k;
    endfunction

    // Build the next byte of a well-formed stream, with some noise and restarts
    function automatic in_word_t next_stream_byte(input bit force_start);
        in_word_t    w;
        phase_t      ph;
        logic [7:0]  fl;
        int          reach;
        int          back_dist;
        logic [3:0]  nib;
        w.in_byte      = 8'($urandom);
        w.stream_start = force_start || ($urandom_range(0, 99) < 2) ||
                         (size_reached() && $urandom_range(0, 99) < 60);
        ph    = w.stream_start ? PH_FLAG : phase;
        fl    = w.stream_start ? 8'h00 : flags;
        reach = history_reach(w.stream_start ? '0 : wr_ptr);
        if (!w.stream_start && size_reached())
            return w;
        case (ph)
            PH_FLAG:
            begin
                if (reach == 0)
                    w.in_byte[7] = 1'b1;
            end
            PH_TOKEN:
            begin
                if (!fl[TOP_FLAG])
                begin
                    if ($urandom_range(0, 1) == 0 && reach > 16)
                        back_dist = $urandom_range(1, 16);
                    else
                        back_dist = $urandom_range(1, reach);
                    gen_off = 12'(back_dist - 1);
                    nib = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
                    w.in_byte = {nib, gen_off[11:8]};
                end
            end
            PH_SECOND:
                w.in_byte = gen_off[7:0];
            default:
            begin
                if ($urandom_range(0, 9) != 0)
                    w.in_byte = 8'($urandom_range(0, 40));
            end
        endcase
        return w;
    endfunction

    // Clock: 20 ns period
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Predict on accepted input words, check accepted output words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                size_cfg <= cfg_wdata;
            if (in_valid && in_ready)
                decode_byte(in_word);
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                    report("output word with nothing expected");
                else
                begin
                    out_word_t e;
                    e = decoded_q.pop_front();
                    if (out_word.out_data !== e.out_data)
                        report($sformatf("out_data %h, expected %h",
                                         out_word.out_data, e.out_data));
                    if (out_word.out_count !== e.out_count)
                        report($sformatf("out_count %0d, expected %0d",
                                         out_word.out_count, e.out_count));
                    if (out_word.run_last !== e.run_last)
                        report($sformatf("run_last %b, expected %b",
                                         out_word.run_last, e.run_last));
                    if (out_word.stream_done !== e.stream_done)
                        report($sformatf("stream_done %b, expected %b",
                                         out_word.stream_done, e.stream_done));
                end
            end
        end
    end

    // Receiver: stall at random
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    task automatic send_word(input in_word_t w);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_word  = w;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Hold until every result is out, then let the core settle
    task automatic wait_drained();
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_size(input logic [23:0] v);
        wait_drained();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    function automatic row_t mk(input bit cs, input logic [23:0] cv, input logic [7:0] b,
                                input bit st, input bit chk, input logic [63:0] d,
                                input int cnt, input bit last, input bit done);
        row_t r;
        r.cfg_set = cs;
        r.cfg_val = cv;
        r.w.in_byte = b;
        r.w.stream_start = st;
        r.chk = chk;
        r.e.out_data = d;
        r.e.out_count = CNT_W'(cnt);
        r.e.run_last = last;
        r.e.stream_done = done;
        return r;
    endfunction

    initial
    begin
        logic [23:0] sz;
        errors     = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        out_ready  = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        send_idle_pct = 38;
        recv_idle_pct = 56;
        gen_off    = '0;
        wr_ptr     = '0;
        flags      = '0;
        flags_left = '0;
        phase      = PH_FLAG;
        ref_nib    = '0;
        ref_off    = '0;
        produced   = '0;
        size_cfg   = '0;
        for (int i = 0; i < WIN_DEPTH; i++)
        begin
            hist[i] = '0;
            hist_written[i] = 1'b0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: literals at both byte extremes, short and long references,
        // clipping at the size, ignored bytes, and a zero size
        rows.push_back(mk(1, 24'd20, 8'hC0, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 8'h00, 0, 1, 64'h00, 1, 1, 0));
        rows.push_back(mk(0, 0, 8'hFF, 0, 1, 64'hFF, 1, 1, 0));
        rows.push_back(mk(0, 0, 8'hF0, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 8'h00, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 8'h00, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 8'h01, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 8'h00, 0, 1, 64'hFF, 1, 1, 1));
        rows.push_back(mk(0, 0, 8'h55, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 8'hFF, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 8'h7E, 0, 1, 64'h7E, 1, 1, 0));
        rows.push_back(mk(0, 0, 8'h10, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 8'h00, 0, 0, 0, 0, 0, 0));
        rows.push_back(mk(1, 24'd0, 8'hAA, 1, 0, 0, 0, 0, 0));
        rows.push_back(mk(0, 0, 8'hFF, 0, 0, 0, 0, 0, 0));
        foreach (rows[i])
        begin
            if (rows[i].cfg_set)
                write_size(rows[i].cfg_val);
            send_word(rows[i].w);
            if (rows[i].chk && (!had_decoded || first_decoded !== rows[i].e))
                report($sformatf("directed word %0d decoded wrong", i));
            if (rows[i].chk == 0 && had_decoded && rows[i].w.stream_start && size_cfg == 0)
                report("byte decoded with zero size");
        end

        // Random streams over several sizes and idling patterns
        for (int p = 0; p < N_PHASE; p++)
        begin
            case (p)
                0: sz = SIZE_MAX;
                1: sz = 24'd1;
                2: sz = 24'($urandom_range(20, 300));
                3: sz = SIZE_MAX;
                4: sz = 24'($urandom_range(2, 60));
                default: sz = 24'($urandom_range(100, 2000));
            endcase
            if (p == 2)
            begin
                send_idle_pct = 56;
                recv_idle_pct = 38;
            end
            else if (p == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_size(sz);
            for (int i = 0; i < PER_PHASE; i++)
            begin
                if (p == 3 && i == PER_PHASE / 2)
                    wait_drained();
                send_word(next_stream_byte(i == 0));
            end
        end

        wait_drained();
        if (errors == 0)
            $display("yaz0_lz_decompressor_core verification clean");
        else
            $display("yaz0_lz_decompressor_core verification failed");
        $finish;
    end

    // Run limit
    initial
    begin
        #20ms;
        $display("yaz0_lz_decompressor_core verification failed");
        $finish;
    end

endmodule
